// File: rtl/sdaf_pkg.sv
// ----------------------------------------------------------------------------
// sdaf_pkg
// shared types and constants of the signed decimal ascii formatter
// ----------------------------------------------------------------------------
`default_nettype none

package sdaf_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int MIN_BITS      = 4;
    localparam int CHAR_BITS     = 8;
    localparam int MAX_CHARS_DEF = 14;

    // decimal digits needed for a magnitude of VALUE_BITS bits
    localparam int DIGITS   = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS = DIGITS * 4;
    localparam int DIW      = $clog2(DIGITS);

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'h2D;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [MIN_BITS-1:0]          min_digits;
    } sdaf_in_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } sdaf_out_t;

    typedef struct packed {
        logic                negative;
        logic [MIN_BITS-1:0] min_digits;
    } sdaf_job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sdaf_stat_t;

endpackage

`default_nettype wire

// File: rtl/signed_decimal_ascii_formatter.sv
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter
// prints a signed integer as zero padded decimal ascii, one character a request
// ----------------------------------------------------------------------------
// Each number request is converted by a bit-serial shift-and-add-3 unit, one
// magnitude bit per cycle, then a scan from the top bcd digit finds the first
// significant digit, then one character per cycle goes to the output register
// while the sink keeps taking them. The block takes no new number until the
// last character of the current one has been loaded into the output register;
// that character may still be waiting. The most negative value prints with its
// full unsigned magnitude, and min_digits above MAX_CHARS - 1 acts as
// MAX_CHARS - 1.
`default_nettype none

module signed_decimal_ascii_formatter #(
    parameter int MAX_CHARS = sdaf_pkg::MAX_CHARS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          number_valid,
    output logic               number_ready,
    input  wire sdaf_pkg::sdaf_in_t number,
    output logic               symbol_valid,
    input  wire logic          symbol_ready,
    output sdaf_pkg::sdaf_out_t symbol
);
    import sdaf_pkg::*;

    logic                  busy_reg, busy_next;
    sdaf_job_t             job_reg, job_next;
    logic                  accept;
    logic                  negative;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] magnitude;
    logic [BCD_BITS-1:0]   bcd;
    sdaf_stat_t            dab_stat;
    sdaf_stat_t            emit_stat;

    assign number_ready = !busy_reg;
    assign accept       = number_valid && number_ready;

    assign raw       = number.value;
    assign negative  = raw[VALUE_BITS-1];
    // unsigned negation keeps the most negative value intact
    assign magnitude = negative ? (~raw + VALUE_BITS'(1)) : raw;

    always_comb
    begin
        busy_next = busy_reg;
        job_next  = job_reg;
        if (accept)
        begin
            busy_next           = 1'b1;
            job_next.negative   = negative;
            job_next.min_digits = number.min_digits;
        end
        else if (emit_stat.done)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    sdaf_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .magnitude (magnitude),
        .bcd       (bcd),
        .stat      (dab_stat)
    );

    sdaf_emit #(
        .MAX_CHARS (MAX_CHARS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (dab_stat.done),
        .job          (job_reg),
        .bcd          (bcd),
        .symbol_valid (symbol_valid),
        .symbol_ready (symbol_ready),
        .symbol       (symbol),
        .stat         (emit_stat)
    );

`ifndef SYNTHESIS
    // a new number is never taken while one is still in flight
    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !number_ready)
        else $error("number accepted while busy");

    // conversion only finishes into an idle sequencer
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        dab_stat.done |-> !emit_stat.busy)
        else $error("bcd result arrived while emitting");

    // the converter never runs while the sequencer emits
    a_one_stage: assert property (@(posedge clk) disable iff (!rst_n)
        !(dab_stat.busy && emit_stat.busy))
        else $error("converter and sequencer active together");

    // only a sign or a decimal digit leaves the block
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid |-> (symbol.character == ASCII_MINUS ||
                          (symbol.character >= ASCII_ZERO &&
                           symbol.character <= ASCII_NINE)))
        else $error("character outside sign and digits");
`endif

endmodule

`default_nettype wire

// File: rtl/sdaf_dabble.sv
// ----------------------------------------------------------------------------
// sdaf_dabble
// iterative shift-and-add-3 binary to bcd converter, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sdaf_dabble (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [sdaf_pkg::VALUE_BITS-1:0] magnitude,
    output logic [sdaf_pkg::BCD_BITS-1:0]       bcd,
    output sdaf_pkg::sdaf_stat_t                stat
);
    import sdaf_pkg::*;

    localparam int STEP_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [BCD_BITS-1:0]   adj;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    always_comb
    begin
        // every digit of five or more gets three added before the shift
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = magnitude;
            bcd_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next  = {adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
            bin_next  = {bin_reg[VALUE_BITS-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd       = bcd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// File: rtl/sdaf_emit.sv
// ----------------------------------------------------------------------------
// sdaf_emit
// leading zero scan and character sequencer with output register
// ----------------------------------------------------------------------------
`default_nettype none

module sdaf_emit #(
    parameter int MAX_CHARS = sdaf_pkg::MAX_CHARS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire sdaf_pkg::sdaf_job_t       job,
    input  wire logic [sdaf_pkg::BCD_BITS-1:0] bcd,
    output logic                           symbol_valid,
    input  wire logic                      symbol_ready,
    output sdaf_pkg::sdaf_out_t            symbol,
    output sdaf_pkg::sdaf_stat_t           stat
);
    import sdaf_pkg::*;

    localparam int PAD_MAX = (1 << MIN_BITS) - 1;
    localparam int CNT_MAX = ((DIGITS > PAD_MAX) ? DIGITS : PAD_MAX) + 1;
    localparam int SPAN    = (CNT_MAX > MAX_CHARS) ? CNT_MAX : MAX_CHARS;
    localparam int CW      = $clog2(SPAN + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   want_reg, want_next;
    logic [CW-1:0]   ndig_reg, ndig_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;
    sdaf_out_t       out_reg, out_next;
    logic            done_reg, done_next;

    logic [3:0]      digit [2**DIW];
    logic [3:0]      top_digit;
    logic [3:0]      digit_at;
    logic [CW-1:0]   want_in;
    logic [CW-1:0]   count_w;
    logic [CW-1:0]   total_w;
    logic            load;
    logic [CHAR_BITS-1:0] char_w;

    always_comb
    begin
        for (int i = 0; i < 2**DIW; i++)
        begin
            if (i < DIGITS)
                digit[i] = bcd[4*i +: 4];
            else
                digit[i] = 4'd0;
        end
    end

    assign top_digit = digit[DIW'(ndig_reg - CW'(1))];
    assign digit_at  = (pos_reg < CW'(DIGITS)) ? digit[DIW'(pos_reg)] : 4'd0;

    // minimum count saturates so the sign still fits
    assign want_in = (CW'(job.min_digits) > CW'(MAX_CHARS - 1)) ?
                     CW'(MAX_CHARS - 1) : CW'(job.min_digits);

    assign count_w = ((ndig_reg > want_reg) ? ndig_reg : want_reg) + CW'(neg_reg);
    assign total_w = (count_w > CW'(MAX_CHARS)) ? CW'(MAX_CHARS) : count_w;

    // the sign sits above all digits, so it drops out when characters are cut
    assign char_w = (neg_reg && (pos_reg == count_reg - CW'(1))) ?
                    ASCII_MINUS : ASCII_ZERO + {4'd0, digit_at};

    assign load = (state_reg == ST_EMIT) && (!out_valid_reg || symbol_ready);

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        want_next      = want_reg;
        ndig_next      = ndig_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        done_next      = 1'b0;
        out_valid_next = out_valid_reg;
        if (symbol_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next   = job.negative;
                    want_next  = want_in;
                    ndig_next  = CW'(DIGITS);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((ndig_reg > CW'(1)) && (top_digit == 4'd0))
                    ndig_next = ndig_reg - CW'(1);
                else
                begin
                    count_next = count_w;
                    pos_next   = total_w - CW'(1);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next    = 1'b1;
                    out_next.character = char_w;
                    out_next.last      = (pos_reg == '0);
                    if (pos_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        pos_next = pos_reg - CW'(1);
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        want_reg  <= want_next;
        ndig_reg  <= ndig_next;
        pos_reg   <= pos_next;
        count_reg <= count_next;
        out_reg   <= out_next;
    end

    assign symbol_valid = out_valid_reg;
    assign symbol       = out_reg;
    assign stat.busy    = (state_reg != ST_IDLE);
    assign stat.done    = done_reg;

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for signed_decimal_ascii_formatter
// ----------------------------------------------------------------------------
// Number requests are driven at the falling edge, and characters are sampled
// at the rising edge. A predictor in the bench computes the zero padded
// decimal characters of every accepted request. A checker compares each
// character and last flag with the oldest expected one. The run covers
// directed extremes first. Random traffic follows under free flow, sender
// gaps, receiver stalls, both at once, and a long receiver hold-off.
// ----------------------------------------------------------------------------

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sdaf_pkg::*;

    localparam int MAX_CHARS   = MAX_CHARS_DEF;
    localparam int DRAIN_WAIT  = 64;

    logic      clk;
    logic      rst_n;
    logic      number_valid;
    logic      number_ready;
    sdaf_in_t  number;
    logic      symbol_valid;
    logic      symbol_ready;
    sdaf_out_t symbol;

    sdaf_out_t expected_symbols [$];
    int        errors;
    int        numbers_sent;
    int        symbols_seen;
    int        sender_idle_pct;
    int        sink_stall_pct;
    int        hold_request;
    int        hold_left;

    signed_decimal_ascii_formatter #(.MAX_CHARS(MAX_CHARS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_ready (number_ready),
        .number       (number),
        .symbol_valid (symbol_valid),
        .symbol_ready (symbol_ready),
        .symbol       (symbol)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // characters of one number request, most significant first
    function automatic void predict_symbols(input sdaf_in_t req);
        logic [CHAR_BITS-1:0]  rev [$];
        logic [VALUE_BITS-1:0] raw;
        logic [VALUE_BITS-1:0] mag;
        logic                  negative;
        int                    want;
        int                    total;
        sdaf_out_t             s;
        raw      = req.value;
        negative = raw[VALUE_BITS-1];
        mag      = negative ? (~raw + 1'b1) : raw;
        want     = (int'(req.min_digits) > MAX_CHARS - 1) ? MAX_CHARS - 1
                                                           : int'(req.min_digits);
        do
        begin
            rev.push_back(ASCII_ZERO + CHAR_BITS'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        while (rev.size() < want)
            rev.push_back(ASCII_ZERO);
        if (negative)
            rev.push_back(ASCII_MINUS);
        total = (rev.size() > MAX_CHARS) ? MAX_CHARS : rev.size();
        for (int k = 0; k < total; k++)
        begin
            s.character = rev[total - 1 - k];
            s.last      = (k == total - 1);
            expected_symbols.push_back(s);
        end
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_number(input logic signed [VALUE_BITS-1:0] v,
                               input logic [MIN_BITS-1:0] m);
        sdaf_in_t req;
        req.value      = v;
        req.min_digits = m;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            number_valid <= 1'b0;
            @(negedge clk);
        end
        number_valid <= 1'b1;
        number       <= req;
        @(posedge clk);
        while (!number_ready)
            @(posedge clk);
        predict_symbols(req);
        numbers_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        number_valid <= 1'b0;
        while (expected_symbols.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] random_value();
        longint p;
        longint v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 99);
            1:
            begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
            2: v = ($urandom_range(0, 1) != 0) ? 64'sh7fff_ffff : 64'sh8000_0000;
            3: v = $urandom_range(0, 99999);
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 1) != 0)
            v = -v;
        return VALUE_BITS'(v);
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_number(random_value(), MIN_BITS'($urandom_range(0, 15)));
    endtask

    task automatic test_directed_cases();
        int dir_val [22] = '{0, 0, 1, -1, -1, 2147483647, 2147483647,
                             -2147483647 - 1, -2147483647 - 1, -2147483647 - 1,
                             9, 10, -10, 999999999, 1000000000, -1000000000,
                             12345, -7, 42, 123, 0, 5};
        int dir_min [22] = '{0, 13, 0, 0, 15, 0, 14, 0, 13, 15,
                             2, 1, 5, 0, 0, 12, 3, 9, 10, 11, 15, 14};
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        for (int i = 0; i < 22; i++)
            send_number(dir_val[i], MIN_BITS'(dir_min[i]));
        wait_drained();
    endtask

    task automatic test_free_flow();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        run_random(110);
        wait_drained();
    endtask

    task automatic test_sender_gaps();
        sender_idle_pct = 68;
        sink_stall_pct  = 0;
        run_random(100);
        wait_drained();
    endtask

    task automatic test_receiver_stalls();
        sender_idle_pct = 0;
        sink_stall_pct  = 68;
        run_random(100);
        wait_drained();
    endtask

    task automatic test_mixed_idling();
        sender_idle_pct = 16;
        sink_stall_pct  = 16;
        run_random(100);
        wait_drained();
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        hold_request    = 300;
        run_random(8);
        run_random(30);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            symbol_ready <= 1'b0;
        end
        else
            symbol_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        sdaf_out_t exp_s;
        if (rst_n && symbol_valid && symbol_ready)
        begin
            symbols_seen++;
            if (expected_symbols.size() == 0)
            begin
                $error("unexpected character 0x%02h last %0b", symbol.character,
                       symbol.last);
                errors++;
            end
            else
            begin
                exp_s = expected_symbols.pop_front();
                if (symbol.character !== exp_s.character)
                begin
                    $error("character: expected 0x%02h actual 0x%02h",
                           exp_s.character, symbol.character);
                    errors++;
                end
                if (symbol.last !== exp_s.last)
                begin
                    $error("last: expected %0b actual %0b", exp_s.last, symbol.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        number_valid    = 1'b0;
        number          = '0;
        symbol_ready    = 1'b0;
        errors          = 0;
        numbers_sent    = 0;
        symbols_seen    = 0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        hold_request    = 0;
        hold_left       = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_free_flow();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_output_backpressure();

        wait_drained();
        if (expected_symbols.size() != 0)
        begin
            $error("%0d expected characters never arrived", expected_symbols.size());
            errors++;
        end
        $display("covered %0d numbers, %0d characters: extremes, padding, sign",
                 numbers_sent, symbols_seen);
        $display("traffic phases: free flow, sender gaps, sink stalls, mixed, hold-off");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
